// ----- src/qhs_pkg.sv -----
// Shared types, constants and helpers for the quintic Hermite segment evaluator.
package qhs_pkg;

    localparam int T_W      = 17;
    localparam int T_FRAC   = 16;
    localparam int P_W      = 31;
    localparam int P_FRAC   = 30;
    localparam int NPOW     = 5;
    localparam int NREG     = 6;
    localparam int REG_W    = 64;
    localparam int COMP_W   = 32;
    localparam int W_W      = 42;
    localparam int MODE_W   = 2;
    localparam int ADDR_W   = 3;

    localparam logic [T_W-1:0] T_ONE   = T_W'(1) << T_FRAC;
    localparam logic [P_W-1:0] Q30_ONE = P_W'(1) << P_FRAC;

    localparam logic [MODE_W-1:0] MODE_POS  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VEL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ACC  = 2'd2;

    localparam logic [ADDR_W-1:0] CFG_START_POS = 3'd0;
    localparam logic [ADDR_W-1:0] CFG_START_VEL = 3'd1;
    localparam logic [ADDR_W-1:0] CFG_START_ACC = 3'd2;
    localparam logic [ADDR_W-1:0] CFG_END_ACC   = 3'd3;
    localparam logic [ADDR_W-1:0] CFG_END_VEL   = 3'd4;
    localparam logic [ADDR_W-1:0] CFG_END_POS   = 3'd5;

    typedef struct packed {
        logic [NPOW-1:0][P_W-1:0] p;
        logic [MODE_W-1:0]        mode;
    } t_pow;

    typedef logic [NREG-1:0][W_W-1:0]   t_wgt;
    typedef logic [NREG-1:0][REG_W-1:0] t_cfg;

    function automatic logic [P_W-1:0] q30_mul(input logic [P_W-1:0] a,
                                               input logic [P_W-1:0] b);
        logic [2*P_W-1:0] m;
        m = ((2*P_W)'(a) * (2*P_W)'(b)) + ((2*P_W)'(1) << (P_FRAC - 1));
        return m[P_FRAC+P_W-1:P_FRAC];
    endfunction

endpackage

// ----- src/qhs_powers.sv -----
// Pipelined power series of t in Q.30: clamp, then t^2 through t^5.
module qhs_powers (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [qhs_pkg::T_W-1:0]  i_t,
    input  logic [qhs_pkg::MODE_W-1:0] i_mode,
    output logic                     o_valid,
    input  logic                     i_ready,
    output qhs_pkg::t_pow            o_pow
);
    import qhs_pkg::*;

    localparam int NP = NPOW;

    logic [NP-1:0]    r_vld;
    logic [NP-1:0]    w_en;
    t_pow             r_s [NP];
    t_pow             n_s [NP];
    logic [T_W-1:0]   w_tc;

    always_comb begin
        w_en[NP-1] = !r_vld[NP-1] || i_ready;
        for (int k = NP - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_comb begin
        w_tc = (i_t > T_ONE) ? T_ONE : i_t;
        n_s[0]      = '0;
        n_s[0].mode = i_mode;
        n_s[0].p[0] = P_W'(w_tc) << (P_FRAC - T_FRAC);
        for (int k = 1; k < NP; k++) begin
            n_s[k]      = r_s[k-1];
            n_s[k].p[k] = q30_mul(r_s[k-1].p[k-1], r_s[k-1].p[0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NP; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NP; k++) begin
            if (w_en[k]) begin
                r_s[k] <= n_s[k];
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[NP-1];
    assign o_pow   = r_s[NP-1];

`ifndef SYNTHESIS
    a_t_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r_s[0].p[0] <= Q30_ONE))
        else $error("clamped t exceeds one");

    a_pow_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NP-1] |-> (r_s[NP-1].p[4] <= r_s[NP-1].p[3]))
        else $error("t^5 larger than t^4");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NP-1] && !i_ready) |=> r_vld[NP-1])
        else $error("stalled request dropped");
`endif

endmodule

// ----- src/qhs_weights.sv -----
// Basis weights for position, first and second derivative, one register stage.
module qhs_weights (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  qhs_pkg::t_pow  i_pow,
    output logic           o_valid,
    input  logic           i_ready,
    output qhs_pkg::t_wgt  o_wgt
);
    import qhs_pkg::*;

    logic                  r_vld;
    logic                  w_en;
    t_wgt                  r_wgt;
    t_wgt                  n_wgt;
    logic signed [W_W-1:0] one_q, q1, q2, q3, q4, q5;
    logic signed [W_W-1:0] w0, w1, w2, w3, w4, w5;

    assign w_en = !r_vld || i_ready;

    always_comb begin
        one_q = $signed(W_W'(Q30_ONE));
        q1    = $signed(W_W'(i_pow.p[0]));
        q2    = $signed(W_W'(i_pow.p[1]));
        q3    = $signed(W_W'(i_pow.p[2]));
        q4    = $signed(W_W'(i_pow.p[3]));
        q5    = $signed(W_W'(i_pow.p[4]));
        unique case (i_pow.mode)
            MODE_POS: begin
                w0 = 2 * (one_q - 10 * q3 + 15 * q4 - 6 * q5);
                w1 = 2 * (q1 - 6 * q3 + 8 * q4 - 3 * q5);
                w2 = q2 - 3 * q3 + 3 * q4 - q5;
                w3 = q3 - 2 * q4 + q5;
                w4 = 2 * (-4 * q3 + 7 * q4 - 3 * q5);
                w5 = 2 * (10 * q3 - 15 * q4 + 6 * q5);
            end
            MODE_VEL: begin
                w0 = 2 * (-30 * q2 + 60 * q3 - 30 * q4);
                w1 = 2 * (one_q - 18 * q2 + 32 * q3 - 15 * q4);
                w2 = 2 * q1 - 9 * q2 + 12 * q3 - 5 * q4;
                w3 = 3 * q2 - 8 * q3 + 5 * q4;
                w4 = 2 * (-12 * q2 + 28 * q3 - 15 * q4);
                w5 = 2 * (30 * q2 - 60 * q3 + 30 * q4);
            end
            MODE_ACC: begin
                w0 = 2 * (-60 * q1 + 180 * q2 - 120 * q3);
                w1 = 2 * (-36 * q1 + 96 * q2 - 60 * q3);
                w2 = 2 * (one_q - 9 * q1 + 18 * q2 - 10 * q3);
                w3 = 2 * (3 * q1 - 12 * q2 + 10 * q3);
                w4 = 2 * (-24 * q1 + 84 * q2 - 60 * q3);
                w5 = 2 * (60 * q1 - 180 * q2 + 120 * q3);
            end
            default: begin
                w0 = '0;
                w1 = '0;
                w2 = '0;
                w3 = '0;
                w4 = '0;
                w5 = '0;
            end
        endcase
        n_wgt = {w5, w4, w3, w2, w1, w0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_wgt <= n_wgt;
        end
    end

    assign o_ready = w_en;
    assign o_valid = r_vld;
    assign o_wgt   = r_wgt;

endmodule

// ----- src/qhs_combine.sv -----
// Weighted sum of the control vectors, rounding and saturation, five stages.
module qhs_combine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  qhs_pkg::t_wgt               i_wgt,
    input  qhs_pkg::t_cfg               i_cfg,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [qhs_pkg::COMP_W-1:0]  o_result_x,
    output logic [qhs_pkg::COMP_W-1:0]  o_result_y,
    output logic                        o_saturated
);
    import qhs_pkg::*;

    localparam int NC    = 5;
    localparam int HALF  = COMP_W / 2;
    localparam int PH_W  = W_W + HALF;
    localparam int PL_W  = W_W + HALF + 1;
    localparam int SUM_W = PL_W + 3;
    localparam int S_W   = SUM_W + HALF;
    localparam int RSH   = P_FRAC + 1;
    localparam int V_W   = S_W - RSH;

    localparam logic signed [S_W-1:0] RND = S_W'(1) <<< P_FRAC;
    localparam logic [COMP_W-1:0] CMAX = {1'b0, {(COMP_W-1){1'b1}}};
    localparam logic [COMP_W-1:0] CMIN = {1'b1, {(COMP_W-1){1'b0}}};

    logic [NC-1:0]               r_vld;
    logic [NC-1:0]               w_en;
    logic signed [PH_W-1:0]      r_ph [2][NREG];
    logic signed [PL_W-1:0]      r_pl [2][NREG];
    logic signed [SUM_W-1:0]     r_h2 [2][3];
    logic signed [SUM_W-1:0]     r_l2 [2][3];
    logic signed [SUM_W-1:0]     r_hs [2];
    logic signed [SUM_W-1:0]     r_ls [2];
    logic signed [V_W-1:0]       r_vq [2];
    logic signed [S_W-1:0]       w_s  [2];
    logic [1:0]                  w_ovf;
    logic [COMP_W-1:0]           w_c  [2];
    logic [COMP_W-1:0]           r_x;
    logic [COMP_W-1:0]           r_y;
    logic                        r_sat;

    always_comb begin
        w_en[NC-1] = !r_vld[NC-1] || i_ready;
        for (int k = NC - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NC; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            for (int c = 0; c < 2; c++) begin
                for (int i = 0; i < NREG; i++) begin
                    r_ph[c][i] <= PH_W'($signed(i_wgt[i]))
                        * PH_W'($signed(i_cfg[i][c*COMP_W+HALF +: HALF]));
                    r_pl[c][i] <= PL_W'($signed(i_wgt[i]))
                        * PL_W'($signed({1'b0, i_cfg[i][c*COMP_W +: HALF]}));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            for (int c = 0; c < 2; c++) begin
                for (int j = 0; j < 3; j++) begin
                    r_h2[c][j] <= SUM_W'(r_ph[c][2*j]) + SUM_W'(r_ph[c][2*j+1]);
                    r_l2[c][j] <= SUM_W'(r_pl[c][2*j]) + SUM_W'(r_pl[c][2*j+1]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            for (int c = 0; c < 2; c++) begin
                r_hs[c] <= r_h2[c][0] + r_h2[c][1] + r_h2[c][2];
                r_ls[c] <= r_l2[c][0] + r_l2[c][1] + r_l2[c][2];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            w_s[c] = (S_W'(r_hs[c]) <<< HALF) + S_W'(r_ls[c]) + RND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            for (int c = 0; c < 2; c++) begin
                r_vq[c] <= V_W'(w_s[c] >>> RSH);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            w_ovf[c] = (r_vq[c][V_W-1:COMP_W-1] != {(V_W-COMP_W+1){r_vq[c][COMP_W-1]}});
            if (w_ovf[c]) begin
                w_c[c] = r_vq[c][V_W-1] ? CMIN : CMAX;
            end else begin
                w_c[c] = r_vq[c][COMP_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_x   <= w_c[0];
            r_y   <= w_c[1];
            r_sat <= |w_ovf;
        end
    end

    assign o_ready     = w_en[0];
    assign o_valid     = r_vld[NC-1];
    assign o_result_x  = r_x;
    assign o_result_y  = r_y;
    assign o_saturated = r_sat;

`ifndef SYNTHESIS
    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NC-1] && r_sat) |->
            (r_x == CMAX || r_x == CMIN || r_y == CMAX || r_y == CMIN))
        else $error("saturation flag without clamped component");

    a_pass_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3] && w_en[4] && !w_ovf[0]) |=> (r_x == $past(r_vq[0][COMP_W-1:0])))
        else $error("in-range x altered by clamp");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NC-1] && !i_ready) |=> r_vld[NC-1])
        else $error("stalled result dropped");
`endif

endmodule

// ----- src/quintic_hermite_segment_eval_top.sv -----
// Quintic Hermite segment evaluator top level: config registers and stream ports.
// Each request (t, mode) returns one 2D result: position, first or second
// derivative of the configured segment, signed Q16.16 per axis, clamped to
// 32 bits with a saturation flag. The datapath is an 11-stage pipeline
// (5 stages of t powers, 1 stage of basis weights, 5 stages of multiply,
// adder tree, rounding and clamp) that takes one request per clock while the
// output is not stalled. Each stage holds its own valid bit, so bubbles close
// up under backpressure. Write the six control vectors only while no request
// is in flight; writes to indexes above 5 are ignored.
module quintic_hermite_segment_eval_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [23:0]                    i_s_axis_tdata,  // [16:0] param_t
    input  logic [qhs_pkg::MODE_W-1:0]     i_s_axis_tuser,  // [1:0] mode
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [2*qhs_pkg::COMP_W-1:0]   o_m_axis_tdata,  // [31:0] result_x, [63:32] result_y
    output logic [0:0]                     o_m_axis_tuser,  // [0] saturated
    input  logic                           i_cfg_we,
    input  logic [qhs_pkg::ADDR_W-1:0]     i_cfg_addr,
    input  logic [qhs_pkg::REG_W-1:0]      i_cfg_wdata
);
    import qhs_pkg::*;

    t_cfg              r_cfg;
    logic              w_pw_valid, w_pw_ready;
    t_pow              w_pow;
    logic              w_wg_valid, w_wg_ready;
    t_wgt              w_wgt;
    logic [COMP_W-1:0] w_x, w_y;
    logic              w_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_START_POS: r_cfg[CFG_START_POS] <= i_cfg_wdata;
                CFG_START_VEL: r_cfg[CFG_START_VEL] <= i_cfg_wdata;
                CFG_START_ACC: r_cfg[CFG_START_ACC] <= i_cfg_wdata;
                CFG_END_ACC:   r_cfg[CFG_END_ACC]   <= i_cfg_wdata;
                CFG_END_VEL:   r_cfg[CFG_END_VEL]   <= i_cfg_wdata;
                CFG_END_POS:   r_cfg[CFG_END_POS]   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    qhs_powers u_powers (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_t     (i_s_axis_tdata[T_W-1:0]),
        .i_mode  (i_s_axis_tuser),
        .o_valid (w_pw_valid),
        .i_ready (w_pw_ready),
        .o_pow   (w_pow)
    );

    qhs_weights u_weights (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_pw_valid),
        .o_ready (w_pw_ready),
        .i_pow   (w_pow),
        .o_valid (w_wg_valid),
        .i_ready (w_wg_ready),
        .o_wgt   (w_wgt)
    );

    qhs_combine u_combine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_wg_valid),
        .o_ready     (w_wg_ready),
        .i_wgt       (w_wgt),
        .i_cfg       (r_cfg),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_result_x  (w_x),
        .o_result_y  (w_y),
        .o_saturated (w_sat)
    );

    assign o_m_axis_tdata = {w_y, w_x};
    assign o_m_axis_tuser = w_sat;

endmodule

// ----- sim/quintic_hermite_segment_eval_top_test.sv -----
// Self-checking testbench for the quintic Hermite segment evaluator stream top level.
module quintic_hermite_segment_eval_top_test;
    import qhs_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 7;
    localparam int PIPE_DRAIN = 16;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 120;
    localparam int TDATA_W = 24;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic signed [127:0] COMP_MAX = 128'sd2147483647;
    localparam logic signed [127:0] COMP_MIN = -128'sd2147483648;

    typedef struct packed {
        logic [T_W-1:0]    param_t;
        logic [MODE_W-1:0] mode;
    } t_segment_req;

    typedef struct packed {
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic                     sat;
    } t_segment_result;

    typedef enum int {
        CFG_SMALL,
        CFG_FULL,
        CFG_EXTREME,
        CFG_ALL_MAX,
        CFG_ALL_MIN
    } t_cfg_kind;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_s_axis_tvalid = 1'b0;
    logic                         o_s_axis_tready;
    logic [TDATA_W-1:0]           i_s_axis_tdata = '0;
    logic [MODE_W-1:0]            i_s_axis_tuser = '0;
    logic                         o_m_axis_tvalid;
    logic                         i_m_axis_tready = 1'b0;
    logic [2*COMP_W-1:0]          o_m_axis_tdata;
    logic [0:0]                   o_m_axis_tuser;
    logic                         i_cfg_we = 1'b0;
    logic [ADDR_W-1:0]            i_cfg_addr = '0;
    logic [REG_W-1:0]             i_cfg_wdata = '0;

    logic [REG_W-1:0]             coef_reg [NREG];
    t_segment_req                 pending_reqs [$];
    t_segment_result              expected_results [$];
    int                           sender_idle_pct = 0;
    int                           receiver_stall_pct = 0;
    int                           mismatch_count = 0;
    int                           idle_cycles = 0;
    int                           hold_left = 0;
    bit                           hold_req = 1'b0;
    bit                           hold_seen = 1'b0;

    quintic_hermite_segment_eval_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic t_segment_result eval_segment(input logic [T_W-1:0] t,
                                                     input logic [MODE_W-1:0] mode);
        t_segment_result          res;
        logic [T_W-1:0]           tc;
        longint unsigned          q1, q2, q3, q4, q5;
        longint                   one, p1, p2, p3, p4, p5;
        longint                   w [NREG];
        logic signed [COMP_W-1:0] half;
        logic signed [127:0]      acc, wext, cext;
        logic signed [COMP_W-1:0] comp_val [2];
        res = '0;
        if (mode == MODE_UNUSED) begin
            return res;
        end
        tc = (t > T_ONE) ? T_ONE : t;
        one = longint'(Q30_ONE);
        q1 = longint'(tc) << 14;
        q2 = (q1 * q1 + (64'd1 << 29)) >> 30;
        q3 = (q2 * q1 + (64'd1 << 29)) >> 30;
        q4 = (q3 * q1 + (64'd1 << 29)) >> 30;
        q5 = (q4 * q1 + (64'd1 << 29)) >> 30;
        p1 = q1; p2 = q2; p3 = q3; p4 = q4; p5 = q5;
        case (mode)
            MODE_POS: begin
                w[0] = 2 * (one - 10 * p3 + 15 * p4 - 6 * p5);
                w[1] = 2 * (p1 - 6 * p3 + 8 * p4 - 3 * p5);
                w[2] = p2 - 3 * p3 + 3 * p4 - p5;
                w[3] = p3 - 2 * p4 + p5;
                w[4] = 2 * (-4 * p3 + 7 * p4 - 3 * p5);
                w[5] = 2 * (10 * p3 - 15 * p4 + 6 * p5);
            end
            MODE_VEL: begin
                w[0] = 2 * (-30 * p2 + 60 * p3 - 30 * p4);
                w[1] = 2 * (one - 18 * p2 + 32 * p3 - 15 * p4);
                w[2] = 2 * p1 - 9 * p2 + 12 * p3 - 5 * p4;
                w[3] = 3 * p2 - 8 * p3 + 5 * p4;
                w[4] = 2 * (-12 * p2 + 28 * p3 - 15 * p4);
                w[5] = 2 * (30 * p2 - 60 * p3 + 30 * p4);
            end
            default: begin
                w[0] = 2 * (-60 * p1 + 180 * p2 - 120 * p3);
                w[1] = 2 * (-36 * p1 + 96 * p2 - 60 * p3);
                w[2] = 2 * (one - 9 * p1 + 18 * p2 - 10 * p3);
                w[3] = 2 * (3 * p1 - 12 * p2 + 10 * p3);
                w[4] = 2 * (-24 * p1 + 84 * p2 - 60 * p3);
                w[5] = 2 * (60 * p1 - 180 * p2 + 120 * p3);
            end
        endcase
        for (int k = 0; k < 2; k++) begin
            acc = '0;
            for (int i = 0; i < NREG; i++) begin
                half = k ? coef_reg[i][2*COMP_W-1:COMP_W] : coef_reg[i][COMP_W-1:0];
                wext = w[i];
                cext = half;
                acc += wext * cext;
            end
            acc = (acc + (128'sd1 <<< 30)) >>> 31;
            if (acc > COMP_MAX) begin
                acc = COMP_MAX;
                res.sat = 1'b1;
            end else if (acc < COMP_MIN) begin
                acc = COMP_MIN;
                res.sat = 1'b1;
            end
            comp_val[k] = acc[COMP_W-1:0];
        end
        res.x = comp_val[0];
        res.y = comp_val[1];
        return res;
    endfunction

    function automatic logic [COMP_W-1:0] pick_coord(input t_cfg_kind kind);
        case (kind)
            CFG_SMALL:   return COMP_W'($urandom_range(0, 2**21 - 1) - 2**20);
            CFG_FULL:    return COMP_W'($urandom);
            CFG_ALL_MAX: return 32'h7FFF_FFFF;
            CFG_ALL_MIN: return 32'h8000_0000;
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    function automatic t_segment_req make_random_req();
        t_segment_req req;
        int           pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            req.param_t = T_W'($urandom_range(int'(T_ONE) + 1, 2**T_W - 1));
        end else if (pick < 12) begin
            req.param_t = ($urandom_range(0, 1) == 0) ? '0 : T_ONE;
        end else begin
            req.param_t = T_W'($urandom_range(0, int'(T_ONE)));
        end
        req.mode = ($urandom_range(0, 99) < 6) ? MODE_UNUSED : MODE_W'($urandom_range(0, 2));
        return req;
    endfunction

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || i_s_axis_tvalid || expected_results.size() != 0);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    task automatic load_config(input t_cfg_kind kind);
        logic [REG_W-1:0] value;
        for (int idx = 0; idx < 2**ADDR_W; idx++) begin
            value = {pick_coord(kind), pick_coord(kind)};
            @(posedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_addr <= ADDR_W'(idx);
            i_cfg_wdata <= value;
            if (idx < NREG) begin
                coef_reg[idx] = value;
            end
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int snd_pct, input int rcv_pct, input t_cfg_kind kind,
                             input bit long_hold);
        wait_idle();
        load_config(kind);
        sender_idle_pct = snd_pct;
        receiver_stall_pct = rcv_pct;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            pending_reqs.push_back(make_random_req());
        end
        if (long_hold) begin
            repeat (20) @(posedge i_clk);
            hold_req = ~hold_req;
        end
    endtask

    always @(posedge i_clk) begin : drive_requests
        t_segment_req next_req;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_results.push_back(eval_segment(i_s_axis_tdata[T_W-1:0],
                                                        i_s_axis_tuser));
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    next_req = pending_reqs.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= {{(TDATA_W - T_W){1'b0}}, next_req.param_t};
                    i_s_axis_tuser <= next_req.mode;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_segment_result want;
        t_segment_result got;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.x = o_m_axis_tdata[COMP_W-1:0];
                got.y = o_m_axis_tdata[2*COMP_W-1:COMP_W];
                got.sat = o_m_axis_tuser[0];
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected result: x %h y %h sat %b",
                             $time, got.x, got.y, got.sat);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.x !== want.x) begin
                        $display("%0t result_x mismatch: expected %h got %h",
                                 $time, want.x, got.x);
                        mismatch_count++;
                    end
                    if (got.y !== want.y) begin
                        $display("%0t result_y mismatch: expected %h got %h",
                                 $time, want.y, got.y);
                        mismatch_count++;
                    end
                    if (got.sat !== want.sat) begin
                        $display("%0t saturated mismatch: expected %b got %b",
                                 $time, want.sat, got.sat);
                        mismatch_count++;
                    end
                end
            end
            if (hold_req != hold_seen) begin
                hold_seen <= hold_req;
                hold_left <= HOLD_CYCLES;
                i_m_axis_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                    || i_cfg_we) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [T_W-1:0]    dir_t [$];
        logic [T_W-1:0]    over_t [$];
        logic [MODE_W-1:0] dir_mode [3];
        t_segment_req      req;
        dir_t = '{'0, T_W'(1), T_W'(32768), T_W'(65535), T_ONE};
        over_t = '{T_ONE + T_W'(1), '1};
        dir_mode = '{MODE_POS, MODE_VEL, MODE_ACC};
        for (int i = 0; i < NREG; i++) begin
            coef_reg[i] = '0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero control vectors straight out of reset
        foreach (dir_mode[m]) begin
            req.param_t = T_W'(32768);
            req.mode = dir_mode[m];
            pending_reqs.push_back(req);
        end
        wait_idle();
        load_config(CFG_SMALL);
        foreach (dir_t[i]) begin
            foreach (dir_mode[m]) begin
                req.param_t = dir_t[i];
                req.mode = dir_mode[m];
                pending_reqs.push_back(req);
            end
        end
        foreach (over_t[i]) begin
            req.param_t = over_t[i];
            req.mode = MODE_POS;
            pending_reqs.push_back(req);
            req.mode = MODE_ACC;
            pending_reqs.push_back(req);
        end
        req.mode = MODE_UNUSED;
        req.param_t = '0;
        pending_reqs.push_back(req);
        req.param_t = T_ONE;
        pending_reqs.push_back(req);
        req.param_t = '1;
        pending_reqs.push_back(req);

        run_phase(0, 0, CFG_SMALL, 1'b0);
        run_phase(48, 0, CFG_FULL, 1'b0);
        run_phase(0, 48, CFG_EXTREME, 1'b0);
        run_phase(31, 31, CFG_SMALL, 1'b0);
        run_phase(0, 0, CFG_EXTREME, 1'b1);
        run_phase(31, 31, CFG_FULL, 1'b0);
        run_phase(48, 0, CFG_ALL_MAX, 1'b0);
        run_phase(0, 48, CFG_ALL_MIN, 1'b0);
        wait_idle();

        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
